[hw/rtl/qdt_pkg.sv]
// Package for the quoted delimiter tokenizer: item types, mode and
// quote-state codes, and character constants. No dependencies.
package qdt_pkg;

   localparam int unsigned FIFO_DEPTH_DEFAULT = 8;

   localparam logic [1:0] MODE_PLAIN  = 2'd0;
   localparam logic [1:0] MODE_FUZZY  = 2'd1;
   localparam logic [1:0] MODE_QUOTED = 2'd2;

   localparam logic CSR_SPLIT_MODE = 1'b0;
   localparam logic CSR_DELIMITER  = 1'b1;

   localparam logic [2:0] Q_NORMAL = 3'd0;
   localparam logic [2:0] Q_ESC    = 3'd1;
   localparam logic [2:0] Q_DQ     = 3'd2;
   localparam logic [2:0] Q_DQ_ESC = 3'd3;
   localparam logic [2:0] Q_SQ     = 3'd4;

   localparam logic [7:0] CH_DQ = 8'h22;
   localparam logic [7:0] CH_BS = 8'h5C;
   localparam logic [7:0] CH_SQ = 8'h27;
   localparam logic [7:0] CH_SP = 8'h20;

   localparam logic [7:0] DELIMITER_RESET = 8'd44;

   localparam logic KIND_BYTE   = 1'b0;
   localparam logic KIND_MARKER = 1'b1;

   typedef struct packed {
      logic [7:0] ch;
      logic       end_of_string;
   } req_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] token_byte;
      logic       string_end;
      logic       run_last;
   } rsp_type;

   typedef struct packed {
      logic [2:0] quote_state;
      logic       token_has_bytes;
      logic       in_delim_run;
   } tok_state_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    rsp0;
      rsp_type    rsp1;
   } push_type;

endpackage

[hw/rtl/quoted_delimiter_tokenizer_core.sv]
// Quoted delimiter tokenizer, top level. An accepted item is registered,
// then stepped into results in the result queue, which feeds the output.
// Throughput: one item per cycle while req_stall is low; the result queue
// depth sets how far input runs ahead of output. Reset (synchronous):
// split_mode plain, delimiter 44, tokenizer state cleared, queue empty.
// Uses qdt_pkg, qdt_step, qdt_rsp_fifo.
module quoted_delimiter_tokenizer_core import qdt_pkg::*; #(
   parameter int unsigned FifoDepth = FIFO_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_payload,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_payload,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata
);

   localparam int unsigned CntW = $clog2(FifoDepth + 1);

   logic [1:0]      split_mode_ff;
   logic [7:0]      delimiter_ff;
   logic            item_valid_ff;
   req_type         item_ff;
   push_type        push;
   logic            pop;
   logic [CntW-1:0] fifo_count;

   // room for the item in flight plus this one, two results each
   assign req_stall = item_valid_ff ? (fifo_count > CntW'(FifoDepth - 4))
                                    : (fifo_count > CntW'(FifoDepth - 2));
   assign csr_ready = 1'b1;
   assign pop       = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         split_mode_ff <= MODE_PLAIN;
         delimiter_ff  <= DELIMITER_RESET;
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= req_valid && !req_stall;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SPLIT_MODE: split_mode_ff <= csr_wdata[1:0];
               CSR_DELIMITER:  delimiter_ff  <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         item_ff <= req_payload;
      end
   end

   qdt_step u_step (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (item_valid_ff),
      .in_item    (item_ff),
      .split_mode (split_mode_ff),
      .delimiter  (delimiter_ff),
      .push       (push)
   );

   qdt_rsp_fifo #(
      .Depth (FifoDepth)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (pop),
      .not_empty (rsp_valid),
      .head      (rsp_payload),
      .count     (fifo_count)
   );

endmodule

[hw/rtl/qdt_step.sv]
// Per-byte tokenizer step: tokenizer state register and the logic that
// turns one registered item into up to two results. Uses qdt_pkg.
module qdt_step import qdt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  req_type    in_item,
   input  logic [1:0] split_mode,
   input  logic [7:0] delimiter,
   output push_type   push
);

   tok_state_type state_ff, state_in;

   always_comb begin
      rsp_type    res [2];
      logic [1:0] n;
      logic       esc;
      logic       quote_ch;
      logic [2:0] qs;
      logic [7:0] ch;
      logic       eos;

      ch       = in_item.ch;
      eos      = in_item.end_of_string;
      n        = 2'd0;
      esc      = 1'b0;
      qs       = state_ff.quote_state;
      quote_ch = (ch == CH_DQ) || (ch == CH_BS) || (ch == CH_SQ);
      state_in = state_ff;
      res[0]   = '0;
      res[1]   = '0;

      if (in_valid) begin
         case (split_mode)
            MODE_PLAIN: begin
               if (ch == delimiter) begin
                  res[0] = '{KIND_MARKER, 8'd0, eos, 1'b0};
                  n = 2'd1;
                  state_in.token_has_bytes = 1'b0;
               end else begin
                  res[0] = '{KIND_BYTE, ch, 1'b0, 1'b0};
                  state_in.token_has_bytes = 1'b1;
                  if (eos) begin
                     res[1] = '{KIND_MARKER, 8'd0, 1'b1, 1'b0};
                     n = 2'd2;
                  end else begin
                     n = 2'd1;
                  end
               end
            end
            MODE_FUZZY: begin
               if ((ch == CH_SP) || (ch == delimiter)) begin
                  if (!state_ff.in_delim_run) begin
                     res[0] = '{KIND_MARKER, 8'd0, 1'b0, 1'b0};
                     n = 2'd1;
                  end
                  state_in.in_delim_run    = 1'b1;
                  state_in.token_has_bytes = 1'b0;
               end else begin
                  res[0] = '{KIND_BYTE, ch, 1'b0, 1'b0};
                  n = 2'd1;
                  state_in.in_delim_run    = 1'b0;
                  state_in.token_has_bytes = 1'b1;
               end
               if (eos) begin
                  res[n[0]] = '{KIND_MARKER, 8'd0, 1'b1, 1'b0};
                  n = n + 2'd1;
               end
            end
            MODE_QUOTED: begin
               case (state_ff.quote_state)
                  Q_ESC: begin
                     esc = 1'b1;
                     qs  = Q_NORMAL;
                  end
                  Q_DQ: begin
                     if (ch == CH_DQ) qs = Q_NORMAL;
                     else if (ch == CH_BS) qs = Q_DQ_ESC;
                     else esc = 1'b1;
                  end
                  Q_DQ_ESC: begin
                     esc = 1'b1;
                     qs  = Q_DQ;
                  end
                  Q_SQ: begin
                     if (ch == CH_SQ) qs = Q_NORMAL;
                     else esc = 1'b1;
                  end
                  default: begin
                     if (ch == CH_DQ) qs = Q_DQ;
                     else if (ch == CH_BS) qs = Q_ESC;
                     else if (ch == CH_SQ) qs = Q_SQ;
                     else qs = Q_NORMAL;
                  end
               endcase
               state_in.quote_state = qs;
               if (esc || !quote_ch) begin
                  if ((ch == delimiter) && !esc) begin
                     res[0] = '{KIND_MARKER, 8'd0, eos, 1'b0};
                     state_in.token_has_bytes = 1'b0;
                  end else begin
                     res[0] = '{KIND_BYTE, ch, 1'b0, 1'b0};
                     state_in.token_has_bytes = 1'b1;
                  end
                  n = 2'd1;
               end
               if (eos && state_in.token_has_bytes) begin
                  res[n[0]] = '{KIND_MARKER, 8'd0, 1'b1, 1'b0};
                  n = n + 2'd1;
               end
            end
            default: begin
            end
         endcase
         if (eos) begin
            state_in = '{Q_NORMAL, 1'b0, 1'b0};
         end
         if (n == 2'd2) begin
            res[1].run_last = 1'b1;
         end else if (n == 2'd1) begin
            res[0].run_last = 1'b1;
         end
      end

      push.count = n;
      push.rsp0  = res[0];
      push.rsp1  = res[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{Q_NORMAL, 1'b0, 1'b0};
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[hw/rtl/qdt_rsp_fifo.sv]
// Result queue: takes up to two results per cycle, gives one per cycle on pop.
// Uses qdt_pkg for the result and push types.
module qdt_rsp_fifo import qdt_pkg::*; #(
   parameter int unsigned Depth = FIFO_DEPTH_DEFAULT,
   localparam int unsigned PtrW = $clog2(Depth),
   localparam int unsigned CntW = $clog2(Depth + 1)
) (
   input  logic            clock,
   input  logic            reset,
   input  push_type        push,
   input  logic            pop,
   output logic            not_empty,
   output rsp_type         head,
   output logic [CntW-1:0] count
);

   rsp_type         mem_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in, wr_ptr_p1;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
      ptr_inc = (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
   endfunction

   always_comb begin
      wr_ptr_p1 = ptr_inc(wr_ptr_ff);
      wr_ptr_in = wr_ptr_ff;
      if (push.count == 2'd1) wr_ptr_in = wr_ptr_p1;
      else if (push.count == 2'd2) wr_ptr_in = ptr_inc(wr_ptr_p1);
      rd_ptr_in = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CntW'(push.count) - CntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.rsp0;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_p1] <= push.rsp1;
      end
   end

   assign not_empty = (count_ff != '0);
   assign head      = mem_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule
